@@ hw/rtl/ordered_integer_list_engine_unit_macros.svh @@
// Assertion macros for the ordered integer list engine.
// Used by the RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef ORDERED_INTEGER_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_INTEGER_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define OLLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define OLLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/olle_pkg.sv @@
// Shared constants, codes and helpers for the ordered integer list engine.
// No dependencies; used by olle_ram users and the top level.
package olle_pkg;

  // list geometry
  localparam int Depth      = 16;
  localparam int MaxResults = 16;
  localparam int IdxW       = $clog2(Depth);
  localparam int CntW       = $clog2(Depth + 1);

  // field widths
  localparam int DataW      = 32;
  localparam int OpW        = 3;
  localparam int StatusW    = 2;
  localparam int PosW       = 4;
  localparam int EntryCntW  = 5;

  localparam logic [IdxW:0] DepthWide = (IdxW + 1)'(Depth);

  typedef enum logic [OpW-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_REVERSE = 3'd3,
    OP_SEARCH  = 3'd4,
    OP_DUMP    = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Map a logical list index to a RAM address. The list is a ring that starts
  // at head_ptr and runs up (dir = 0) or down (dir = 1) modulo Depth.
  function automatic logic [IdxW-1:0] phys_idx(input logic [IdxW-1:0] head_ptr,
                                               input logic            dir,
                                               input logic [IdxW-1:0] idx);
    logic [IdxW:0] sum;
    logic [IdxW:0] dif;
    sum = {1'b0, head_ptr} + {1'b0, idx};
    if (sum >= DepthWide) sum = sum - DepthWide;
    dif = {1'b0, head_ptr} - {1'b0, idx};
    if (head_ptr < idx) dif = dif + DepthWide;
    return dir ? dif[IdxW-1:0] : sum[IdxW-1:0];
  endfunction

endpackage

@@ hw/rtl/olle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module olle_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ordered_integer_list_engine_unit.sv @@
// Ordered integer list engine: a bounded list of signed 32-bit entries held in one RAM.
// Depends on olle_pkg, olle_ram and ordered_integer_list_engine_unit_macros.svh.
//
// An item is taken when start_i is high and busy_o is low; each result shows for one
// cycle with done_o and cannot be held off by the receiver. Append, reverse, opcodes
// on a full or empty list and unused opcodes finish at once: the result follows in
// the next cycle and busy_o stays low. Insert, delete and search walk the list one
// entry per cycle through the RAM's single read port, with busy_o high while they
// walk (search stops at its first match). Dump streams one entry per cycle,
// count results in all. Reverse costs nothing in the RAM: the list lives in a ring
// whose start and direction flip. No clearing pass is needed after reset.
module ordered_integer_list_engine_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [olle_pkg::OpW-1:0]            opcode_i,
  input  logic signed [olle_pkg::DataW-1:0]   operand_i,
  output logic                                done_o,
  output logic [olle_pkg::StatusW-1:0]        status_o,
  output logic [olle_pkg::PosW-1:0]           position_o,
  output logic signed [olle_pkg::DataW-1:0]   element_o,
  output logic [olle_pkg::EntryCntW-1:0]      entry_count_o,
  output logic                                last_o
);

  `include "ordered_integer_list_engine_unit_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_e;

  state_e                               state_q, state_d;
  olle_pkg::op_e                        op_q, op_d;
  logic signed [olle_pkg::DataW-1:0]    val_q, val_d;
  logic [olle_pkg::CntW-1:0]            count_q, count_d;
  logic [olle_pkg::IdxW-1:0]            head_q, head_d;
  logic                                 dir_q, dir_d;
  logic [olle_pkg::CntW-1:0]            k_q, k_d;
  logic                                 found_q, found_d;
  logic [olle_pkg::DataW-1:0]           carry_q, carry_d;

  // result register
  logic                                 done_q, done_d;
  olle_pkg::status_e                    status_q, status_d;
  logic [olle_pkg::PosW-1:0]            pos_q, pos_d;
  logic [olle_pkg::DataW-1:0]           elem_q, elem_d;
  logic                                 last_q, last_d;

  // RAM port
  logic                                 ram_we;
  logic [olle_pkg::IdxW-1:0]            ram_waddr;
  logic [olle_pkg::DataW-1:0]           ram_wdata;
  logic [olle_pkg::IdxW-1:0]            ram_raddr;
  logic [olle_pkg::DataW-1:0]           ram_rdata;

  logic                                 is_full;
  logic                                 is_empty;
  logic                                 rd_less;
  logic                                 rd_equal;
  logic                                 dump_last;
  logic [olle_pkg::CntW-1:0]            k_inc;
  logic [olle_pkg::IdxW-1:0]            k_idx;
  logic [olle_pkg::IdxW-1:0]            cnt_idx;

  olle_ram #(
    .Width (olle_pkg::DataW),
    .Depth (olle_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign is_full   = (count_q == olle_pkg::CntW'(olle_pkg::Depth));
  assign is_empty  = (count_q == '0);
  assign rd_less   = ($signed(ram_rdata) < val_q);
  assign rd_equal  = (ram_rdata == val_q);
  assign k_inc     = k_q + olle_pkg::CntW'(1);
  assign k_idx     = k_q[olle_pkg::IdxW-1:0];
  assign cnt_idx   = count_q[olle_pkg::IdxW-1:0];
  assign dump_last = (k_inc == count_q) || (32'(k_inc) == 32'(olle_pkg::MaxResults));

  // control: accept, walk the list, emit results
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    val_d     = val_q;
    count_d   = count_q;
    head_d    = head_q;
    dir_d     = dir_q;
    k_d       = k_q;
    found_d   = found_q;
    carry_d   = carry_q;
    done_d    = 1'b0;
    status_d  = olle_pkg::ST_OK;
    pos_d     = '0;
    elem_d    = '0;
    last_d    = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = olle_pkg::phys_idx(head_q, dir_q, k_idx);
    ram_wdata = carry_q;
    ram_raddr = olle_pkg::phys_idx(head_q, dir_q, k_inc[olle_pkg::IdxW-1:0]);

    case (state_q)
      S_IDLE: begin
        ram_raddr = olle_pkg::phys_idx(head_q, dir_q, '0);
        if (start_i) begin
          op_d    = olle_pkg::op_e'(opcode_i);
          val_d   = operand_i;
          k_d     = '0;
          found_d = 1'b0;
          case (opcode_i)
            olle_pkg::OP_APPEND: begin
              done_d = 1'b1;
              if (is_full) begin
                status_d = olle_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = olle_pkg::phys_idx(head_q, dir_q, cnt_idx);
                ram_wdata = operand_i;
                count_d   = count_q + olle_pkg::CntW'(1);
              end
            end
            olle_pkg::OP_INSERT: begin
              if (is_full) begin
                done_d   = 1'b1;
                status_d = olle_pkg::ST_FULL;
              end else begin
                state_d = S_WALK;
              end
            end
            olle_pkg::OP_DELETE, olle_pkg::OP_SEARCH, olle_pkg::OP_DUMP: begin
              if (is_empty) begin
                done_d   = 1'b1;
                status_d = olle_pkg::ST_EMPTY;
              end else begin
                state_d = S_WALK;
              end
            end
            olle_pkg::OP_REVERSE: begin
              done_d = 1'b1;
              if (is_empty) begin
                status_d = olle_pkg::ST_EMPTY;
              end else begin
                // the old tail becomes the head, walking the other way
                head_d = olle_pkg::phys_idx(head_q, dir_q,
                                            olle_pkg::IdxW'(count_q - olle_pkg::CntW'(1)));
                dir_d  = ~dir_q;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_WALK: begin
        if (k_q < count_q) begin
          // ram_rdata holds entry k_q; the read of k_q + 1 is in flight
          k_d = k_inc;
          case (op_q)
            olle_pkg::OP_INSERT: begin
              if (found_q) begin
                ram_we  = 1'b1;
                carry_d = ram_rdata;
              end else if (!rd_less) begin
                ram_we    = 1'b1;
                ram_wdata = val_q;
                carry_d   = ram_rdata;
                found_d   = 1'b1;
              end
            end
            olle_pkg::OP_DELETE: begin
              if (found_q) begin
                // close the gap: entry k moves down to k - 1
                ram_we    = 1'b1;
                ram_waddr = olle_pkg::phys_idx(head_q, dir_q,
                                               olle_pkg::IdxW'(k_q - olle_pkg::CntW'(1)));
                ram_wdata = ram_rdata;
              end else if (rd_equal) begin
                found_d = 1'b1;
              end
            end
            olle_pkg::OP_SEARCH: begin
              if (rd_equal) begin
                done_d  = 1'b1;
                pos_d   = olle_pkg::PosW'(k_q);
                state_d = S_IDLE;
              end
            end
            olle_pkg::OP_DUMP: begin
              done_d = 1'b1;
              pos_d  = olle_pkg::PosW'(k_q);
              elem_d = ram_rdata;
              last_d = dump_last;
              if (dump_last) state_d = S_IDLE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end else begin
          // past the tail: finish the operation
          state_d = S_IDLE;
          done_d  = 1'b1;
          case (op_q)
            olle_pkg::OP_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = olle_pkg::phys_idx(head_q, dir_q, cnt_idx);
              ram_wdata = found_q ? carry_q : val_q;
              count_d   = count_q + olle_pkg::CntW'(1);
            end
            olle_pkg::OP_DELETE: begin
              if (found_q) begin
                count_d = count_q - olle_pkg::CntW'(1);
              end else begin
                status_d = olle_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              status_d = olle_pkg::ST_NOT_FOUND;
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      dir_q   <= 1'b0;
      k_q     <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      dir_q   <= dir_d;
      k_q     <= k_d;
      found_q <= found_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    carry_q  <= carry_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    elem_q   <= elem_d;
    last_q   <= last_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign position_o    = pos_q;
  assign element_o     = elem_q;
  assign entry_count_o = olle_pkg::EntryCntW'(count_q);
  assign last_o        = last_q;

  // checks
  `OLLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= olle_pkg::CntW'(olle_pkg::Depth), "count above depth")
  `OLLE_ASSERT_NOW(a_walk_bound, state_q == S_WALK, k_q <= count_q, "walk index past count")
  `OLLE_ASSERT_NOW(a_stream_continues, done_o && !last_o, state_q == S_WALK, "dump stream cut short")
  `OLLE_ASSERT_NEXT(a_item_progress, start_i && !busy_o, done_o || busy_o, "accepted item lost")

endmodule
